// File: rtl/rgb_led_blink_breath_controller_top_defines.svh
// -----------------------------------------------------------------------------
// rgb_led_blink_breath_controller_top_defines
// assertion macros shared by the controller modules
// -----------------------------------------------------------------------------
`ifndef RGB_LED_BLINK_BREATH_CONTROLLER_TOP_DEFINES_SVH
`define RGB_LED_BLINK_BREATH_CONTROLLER_TOP_DEFINES_SVH

// checked only outside reset
`define RLBBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked at every edge, reset included
`define RLBBC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// File: rtl/rlbbc_pkg.sv
// -----------------------------------------------------------------------------
// rlbbc_pkg
// types and constants of the rgb led blink and breathing controller
// -----------------------------------------------------------------------------
package rlbbc_pkg;

  localparam int unsigned FlowMsDef   = 300;
  localparam int unsigned FlowLedsDef = 3;

  localparam int unsigned DutyW   = 16;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned NumLeds = 3;

  localparam logic [DutyW-1:0] DutyFull = '1;

  typedef enum logic [1:0] {
    WORK_LIGHT = 2'd0,
    WORK_DARK  = 2'd1,
    WORK_FLOW  = 2'd2,
    WORK_BLINK = 2'd3
  } work_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WORK_SELECT     = 3'd0,
    CFG_BREATH_ENABLE   = 3'd1,
    CFG_COLOUR_MASK     = 3'd2,
    CFG_BLUE_PERIOD     = 3'd3,
    CFG_GREEN_PERIOD    = 3'd4,
    CFG_RED_PERIOD      = 3'd5,
    CFG_BREATH_INTERVAL = 3'd6,
    CFG_BREATH_STEP     = 3'd7
  } cfg_idx_e;

  // pins: bit0 blue, bit1 green, bit2 red, active low
  typedef struct packed {
    logic [NumLeds-1:0] pins;
    logic [DutyW-1:0]   duty;
  } result_t;

endpackage

// File: rtl/rlbbc_in_if.sv
// -----------------------------------------------------------------------------
// rlbbc_in_if
// tick input channel: valid, ready and the two tick flags
// -----------------------------------------------------------------------------
interface rlbbc_in_if;
  logic valid;
  logic ready;
  logic blink_tick;
  logic ms_tick;

  modport source (output valid, output blink_tick, output ms_tick, input ready);
  modport sink   (input valid, input blink_tick, input ms_tick, output ready);
endinterface

// File: rtl/rlbbc_out_if.sv
// -----------------------------------------------------------------------------
// rlbbc_out_if
// result channel: valid, ready, pin levels and breathing duty
// -----------------------------------------------------------------------------
interface rlbbc_out_if;
  logic        valid;
  logic        ready;
  logic        blue_pin;
  logic        green_pin;
  logic        red_pin;
  logic [15:0] pwm_duty;

  modport source (output valid, output blue_pin, output green_pin, output red_pin,
                  output pwm_duty, input ready);
  modport sink   (input valid, input blue_pin, input green_pin, input red_pin,
                  input pwm_duty, output ready);
endinterface

// File: rtl/rlbbc_core.sv
// -----------------------------------------------------------------------------
// rlbbc_core
// configuration registers, blink counters, breathing ramp and flow pattern
// -----------------------------------------------------------------------------
`include "rgb_led_blink_breath_controller_top_defines.svh"

module rlbbc_core
  import rlbbc_pkg::*;
#(
  parameter int unsigned FLOW_MS   = FlowMsDef,
  parameter int unsigned FLOW_LEDS = FlowLedsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               acc_i,
  input  logic               blink_tick_i,
  input  logic               ms_tick_i,
  output result_t            res_o
);

  localparam int unsigned FlowCntW = (FLOW_MS > 1) ? $clog2(FLOW_MS) : 1;
  localparam logic [FlowCntW:0] FlowMsVal = FlowCntW'(FLOW_MS) == '0 && FLOW_MS > 1 ?
                                            (FlowCntW+1)'(FLOW_MS) : (FlowCntW+1)'(FLOW_MS);
  localparam logic [1:0] FlowLedsVal = 2'(FLOW_LEDS);

  // configuration
  work_e              work_q;
  logic               breath_en_q;
  logic [3:0]         mask_q;
  logic [PeriodW-1:0] period_q [NumLeds];
  logic [PeriodW-1:0] interval_q;
  logic [DutyW-1:0]   step_q;

  // state
  logic [PeriodW-1:0] blink_cnt_q [NumLeds];
  logic [PeriodW-1:0] blink_cnt_d [NumLeds];
  logic [NumLeds-1:0] pins_q, pins_d;
  logic [DutyW-1:0]   duty_lvl_q, duty_lvl_d;
  logic               rising_q, rising_d;
  logic [PeriodW-1:0] breath_cnt_q, breath_cnt_d;
  logic [FlowCntW-1:0] flow_cnt_q, flow_cnt_d;
  logic [1:0]         flow_idx_q, flow_idx_d;
  logic [DutyW-1:0]   duty_out_q, duty_out_d;

  logic [PeriodW:0]   cnt_nxt [NumLeds];
  logic [NumLeds-1:0] cnt_hit;
  logic [PeriodW:0]   breath_nxt;
  logic [DutyW:0]     ramp_sum;
  logic [FlowCntW:0]  flow_nxt;
  logic [1:0]         flow_idx_eff;
  logic [1:0]         flow_idx_inc;
  logic               toggle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q      <= WORK_DARK;
      breath_en_q <= 1'b0;
      mask_q      <= '0;
      period_q[0] <= PeriodW'(25);
      period_q[1] <= PeriodW'(25);
      period_q[2] <= PeriodW'(25);
      interval_q  <= PeriodW'(1);
      step_q      <= DutyW'(655);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WORK_SELECT:     work_q      <= work_e'(cfg_data_i[1:0]);
        CFG_BREATH_ENABLE:   breath_en_q <= cfg_data_i[0];
        CFG_COLOUR_MASK:     mask_q      <= cfg_data_i[3:0];
        CFG_BLUE_PERIOD:     period_q[0] <= cfg_data_i;
        CFG_GREEN_PERIOD:    period_q[1] <= cfg_data_i;
        CFG_RED_PERIOD:      period_q[2] <= cfg_data_i;
        CFG_BREATH_INTERVAL: interval_q  <= cfg_data_i;
        CFG_BREATH_STEP:     step_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NumLeds; i++) begin
      cnt_nxt[i] = {1'b0, blink_cnt_q[i]} + (PeriodW+1)'(1);
      // a zero period acts as one
      cnt_hit[i] = (period_q[i] == '0) || (cnt_nxt[i] >= {1'b0, period_q[i]});
    end
    breath_nxt   = {1'b0, breath_cnt_q} + (PeriodW+1)'(1);
    ramp_sum     = {1'b0, duty_lvl_q} + {1'b0, step_q};
    flow_nxt     = {1'b0, flow_cnt_q} + (FlowCntW+1)'(1);
    flow_idx_eff = (flow_idx_q < FlowLedsVal) ? flow_idx_q : 2'd0;
    flow_idx_inc = flow_idx_eff + 2'd1;
    toggle       = blink_tick_i && ((work_q == WORK_BLINK) || breath_en_q);
  end

  always_comb begin
    blink_cnt_d  = blink_cnt_q;
    pins_d       = pins_q;
    duty_lvl_d   = duty_lvl_q;
    rising_d     = rising_q;
    breath_cnt_d = breath_cnt_q;
    flow_cnt_d   = flow_cnt_q;
    flow_idx_d   = flow_idx_q;
    duty_out_d   = duty_out_q;

    if (toggle) begin
      for (int i = 0; i < NumLeds; i++) begin
        if (cnt_hit[i]) begin
          blink_cnt_d[i] = '0;
          if (work_q == WORK_BLINK) begin
            pins_d[i] = mask_q[i] ? ~pins_q[i] : 1'b1;
          end
        end else begin
          blink_cnt_d[i] = cnt_nxt[i][PeriodW-1:0];
        end
      end
      if (mask_q[3] && breath_en_q) begin
        if (breath_nxt >= {1'b0, interval_q}) begin
          breath_cnt_d = '0;
          if (rising_q) begin
            if (ramp_sum >= {1'b0, DutyFull}) begin
              duty_lvl_d = DutyFull;
              rising_d   = 1'b0;
            end else begin
              duty_lvl_d = ramp_sum[DutyW-1:0];
            end
          end else begin
            if (duty_lvl_q <= step_q) begin
              duty_lvl_d = '0;
              rising_d   = 1'b1;
            end else begin
              duty_lvl_d = duty_lvl_q - step_q;
            end
          end
          duty_out_d = duty_lvl_d;
        end else begin
          breath_cnt_d = breath_nxt[PeriodW-1:0];
        end
      end
    end

    unique case (work_q)
      WORK_LIGHT: begin
        pins_d = ~mask_q[NumLeds-1:0];
        if (!breath_en_q) begin
          duty_out_d = mask_q[3] ? '0 : DutyFull;
        end
      end
      WORK_DARK: begin
        pins_d = '1;
        if (!breath_en_q) begin
          duty_out_d = DutyFull;
        end
      end
      WORK_FLOW: begin
        if (ms_tick_i) begin
          if (flow_nxt >= FlowMsVal) begin
            flow_cnt_d = '0;
            for (int i = 0; i < NumLeds; i++) begin
              pins_d[i] = (2'(i) == flow_idx_eff) ? 1'b0 : 1'b1;
            end
            if (!breath_en_q) begin
              duty_out_d = DutyFull;
            end
            flow_idx_d = (flow_idx_inc >= FlowLedsVal) ? 2'd0 : flow_idx_inc;
          end else begin
            flow_cnt_d = flow_nxt[FlowCntW-1:0];
          end
        end
      end
      WORK_BLINK: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_cnt_q[0] <= '0;
      blink_cnt_q[1] <= '0;
      blink_cnt_q[2] <= '0;
      pins_q         <= '1;
      duty_lvl_q     <= '0;
      rising_q       <= 1'b1;
      breath_cnt_q   <= '0;
      flow_cnt_q     <= '0;
      flow_idx_q     <= '0;
      duty_out_q     <= DutyFull;
    end else if (acc_i) begin
      blink_cnt_q    <= blink_cnt_d;
      pins_q         <= pins_d;
      duty_lvl_q     <= duty_lvl_d;
      rising_q       <= rising_d;
      breath_cnt_q   <= breath_cnt_d;
      flow_cnt_q     <= flow_cnt_d;
      flow_idx_q     <= flow_idx_d;
      duty_out_q     <= duty_out_d;
    end
  end

  assign res_o.pins = pins_d;
  assign res_o.duty = duty_out_d;

  `RLBBC_ASSERT(a_flow_idx_range, flow_idx_q < FlowLedsVal, "flow index out of range")
  `RLBBC_ASSERT(a_flow_cnt_range, {1'b0, flow_cnt_q} < FlowMsVal, "flow count overran")
  `RLBBC_ASSERT(a_ramp_turn_top, $fell(rising_q) |-> (duty_lvl_q == DutyFull),
                "ramp turned down below full scale")
  `RLBBC_ASSERT(a_ramp_turn_bottom, $rose(rising_q) |-> (duty_lvl_q == '0),
                "ramp turned up above zero")

endmodule

// File: rtl/rlbbc_outbuf.sv
// -----------------------------------------------------------------------------
// rlbbc_outbuf
// two-entry result buffer, takes a new result while the head is stalled
// -----------------------------------------------------------------------------
`include "rgb_led_blink_breath_controller_top_defines.svh"

module rlbbc_outbuf
  import rlbbc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  result_t     res_i,
  output logic        ready_o,
  rlbbc_out_if.source out_o
);

  result_t head_q, tail_q;
  logic    head_v_q, tail_v_q;
  logic    pop;

  assign pop     = head_v_q && out_o.ready;
  assign ready_o = !tail_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      tail_v_q <= 1'b0;
    end else begin
      priority if (pop && tail_v_q) begin
        tail_v_q <= 1'b0;
      end else if (pop) begin
        head_v_q <= push_i;
      end else if (push_i && head_v_q) begin
        tail_v_q <= 1'b1;
      end else if (push_i) begin
        head_v_q <= 1'b1;
      end else begin
      end
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (pop && tail_v_q) begin
      head_q <= tail_q;
    end else if (push_i && (pop || !head_v_q)) begin
      head_q <= res_i;
    end else if (push_i) begin
      tail_q <= res_i;
    end else begin
    end
  end

  assign out_o.valid     = head_v_q;
  assign out_o.blue_pin  = head_q.pins[0];
  assign out_o.green_pin = head_q.pins[1];
  assign out_o.red_pin   = head_q.pins[2];
  assign out_o.pwm_duty  = head_q.duty;

  `RLBBC_ASSERT(a_tail_needs_head, tail_v_q |-> head_v_q, "tail entry without head entry")
  `RLBBC_ASSERT(a_head_holds, (head_v_q && !out_o.ready) |=> (head_v_q && $stable(head_q)),
                "stalled result changed")
  `RLBBC_ASSERT(a_no_push_when_full, tail_v_q |-> !push_i, "push into full buffer")

endmodule

// File: rtl/rgb_led_blink_breath_controller_top.sv
// -----------------------------------------------------------------------------
// rgb_led_blink_breath_controller_top
// rgb led blink, flow and breathing pwm controller
// -----------------------------------------------------------------------------
// in_i carries one tick per transfer: blink_tick runs the colour blink
// counters and the breathing ramp, ms_tick times the flow pattern.
// out_o returns one result per tick: the three active-low pin levels and the
// breathing duty, 65535 being full scale.
// registers are written through cfg_we_i / cfg_idx_i / cfg_data_i; the user
// must do so only while idle, the block does not enforce it. results are
// registered. throughput: one tick per cycle while in_i.ready is high; each
// tick updates all state in a single registered pass.
// a two-entry result buffer keeps in_i ready while one result is stalled;
// with both entries held, in_i.ready drops until out_o takes a result.
// reset: dark mode, all pins dark, duty 65535, counters and ramp cleared,
// ramp rising, blink periods 25, interval 1, step 655.
// -----------------------------------------------------------------------------
module rgb_led_blink_breath_controller_top
  import rlbbc_pkg::*;
#(
  parameter int unsigned FLOW_MS   = FlowMsDef,
  parameter int unsigned FLOW_LEDS = FlowLedsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  rlbbc_in_if.sink           in_i,
  rlbbc_out_if.source        out_o
);

  logic    acc;
  logic    buf_ready;
  result_t res;

  assign in_i.ready = buf_ready;
  assign acc        = in_i.valid && buf_ready;

  rlbbc_core #(
    .FLOW_MS   (FLOW_MS),
    .FLOW_LEDS (FLOW_LEDS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .acc_i        (acc),
    .blink_tick_i (in_i.blink_tick),
    .ms_tick_i    (in_i.ms_tick),
    .res_o        (res)
  );

  rlbbc_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (acc),
    .res_i   (res),
    .ready_o (buf_ready),
    .out_o   (out_o)
  );

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the rgb led blink, flow and breathing controller.
// A tick driver and a result monitor run around the block. A predictor keeps
// its own copy of the registers and state and computes the pins and the duty
// that each tick transfer should give. Registers are rewritten between phases
// while the block is idle. The phases differ in how often the sender idles and
// the receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  import rlbbc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HoldCycles = 200;
  localparam int unsigned StallLimit = 2000;

  typedef struct packed {
    logic blink;
    logic ms;
  } tick_t;

  bit                 clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_data;

  rlbbc_in_if  in_if ();
  rlbbc_out_if out_if ();

  rgb_led_blink_breath_controller_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // register copy
  work_e       sel_work;
  logic        breath_on;
  logic [3:0]  led_mask;
  logic [15:0] blink_period [NumLeds];
  logic [15:0] ramp_interval;
  logic [15:0] ramp_inc;

  // state copy
  logic [15:0] blink_cnt [NumLeds];
  logic [2:0]  pin_lvl;
  logic [15:0] ramp_duty;
  logic        ramp_up;
  logic [15:0] ramp_cnt;
  logic [8:0]  flow_cnt;
  logic [1:0]  flow_pos;
  logic [15:0] duty_q;

  tick_t   ticks_pending [$];
  result_t results_due [$];
  int      ticks_queued;
  int      ticks_taken;
  int      mismatches;
  int      src_idle_pct;
  int      snk_stall_pct;
  int      hold_ticket;
  int      hold_seen;
  int      hold_left;
  int      stall_cycles;
  bit      in_fire;
  tick_t   cur_tick;

  function automatic result_t advance_leds(input logic blink, input logic ms);
    logic [16:0] nxt;
    logic [15:0] per;
    logic [1:0]  pos;
    result_t     res;
    if (blink && (sel_work == WORK_BLINK || breath_on)) begin
      for (int i = 0; i < NumLeds; i++) begin
        per = (blink_period[i] == '0) ? 16'd1 : blink_period[i];
        nxt = blink_cnt[i] + 17'd1;
        if (nxt >= per) begin
          blink_cnt[i] = '0;
          if (sel_work == WORK_BLINK) pin_lvl[i] = led_mask[i] ? ~pin_lvl[i] : 1'b1;
        end else begin
          blink_cnt[i] = nxt[15:0];
        end
      end
      if (led_mask[3] && breath_on) begin
        nxt = ramp_cnt + 17'd1;
        if (nxt >= ramp_interval) begin
          ramp_cnt = '0;
          // triangle ramp, saturating at both ends
          if (ramp_up) begin
            nxt = ramp_duty + ramp_inc;
            if (nxt >= 17'h0FFFF) begin
              ramp_duty = DutyFull;
              ramp_up   = 1'b0;
            end else begin
              ramp_duty = nxt[15:0];
            end
          end else if (ramp_duty <= ramp_inc) begin
            ramp_duty = '0;
            ramp_up   = 1'b1;
          end else begin
            ramp_duty = ramp_duty - ramp_inc;
          end
          duty_q = ramp_duty;
        end else begin
          ramp_cnt = nxt[15:0];
        end
      end
    end
    case (sel_work)
      WORK_LIGHT: begin
        pin_lvl = ~led_mask[2:0];
        if (!breath_on) duty_q = led_mask[3] ? '0 : DutyFull;
      end
      WORK_DARK: begin
        pin_lvl = '1;
        if (!breath_on) duty_q = DutyFull;
      end
      WORK_FLOW: begin
        if (ms) begin
          nxt = flow_cnt + 17'd1;
          if (nxt >= FlowMsDef) begin
            pos      = (flow_pos < FlowLedsDef) ? flow_pos : 2'd0;
            flow_cnt = '0;
            pin_lvl  = '1;
            if (!breath_on) duty_q = DutyFull;
            pin_lvl[pos] = 1'b0;
            flow_pos = (pos + 1 >= FlowLedsDef) ? 2'd0 : pos + 2'd1;
          end else begin
            flow_cnt = nxt[8:0];
          end
        end
      end
      default: ;
    endcase
    res.pins = pin_lvl;
    res.duty = duty_q;
    return res;
  endfunction

  task automatic check_result(input result_t want);
    result_t got;
    got.pins = {out_if.red_pin, out_if.green_pin, out_if.blue_pin};
    got.duty = out_if.pwm_duty;
    if (got.pins !== want.pins || got.duty !== want.duty) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch at %0t: pins exp %b got %b, duty exp %0d got %0d",
                 $time, want.pins, got.pins, want.duty, got.duty);
    end
  endtask

  // tick driver
  always @(negedge clk_i) begin
    if (!in_if.valid || in_fire) begin
      if (ticks_pending.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        cur_tick = ticks_pending.pop_front();
        in_if.valid      <= 1'b1;
        in_if.blink_tick <= cur_tick.blink;
        in_if.ms_tick    <= cur_tick.ms;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result ready, with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_seen != hold_ticket) begin
      hold_seen = hold_ticket;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // monitor: predict on tick transfers, check on result transfers
  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_if.valid && in_if.ready;
    if (rst_ni && in_if.valid && in_if.ready) begin
      results_due.push_back(advance_leds(in_if.blink_tick, in_if.ms_tick));
      ticks_taken++;
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch at %0t: result with none expected", $time);
      end else begin
        check_result(results_due.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      CFG_WORK_SELECT:     sel_work = work_e'(data[1:0]);
      CFG_BREATH_ENABLE:   breath_on = data[0];
      CFG_COLOUR_MASK:     led_mask = data[3:0];
      CFG_BLUE_PERIOD:     blink_period[0] = data;
      CFG_GREEN_PERIOD:    blink_period[1] = data;
      CFG_RED_PERIOD:      blink_period[2] = data;
      CFG_BREATH_INTERVAL: ramp_interval = data;
      CFG_BREATH_STEP:     ramp_inc = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_count(input int unsigned limit);
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(limit, 1));
    endcase
  endfunction

  task automatic random_config(input work_e ws);
    logic [15:0] data;
    data = 16'($urandom);
    data[1:0] = ws;
    write_reg(CFG_WORK_SELECT, data);
    data = 16'($urandom);
    write_reg(CFG_BREATH_ENABLE, data);
    write_reg(CFG_COLOUR_MASK, 16'($urandom));
    write_reg(CFG_BLUE_PERIOD, pick_count(6));
    write_reg(CFG_GREEN_PERIOD, pick_count(6));
    write_reg(CFG_RED_PERIOD, pick_count(6));
    write_reg(CFG_BREATH_INTERVAL, pick_count(4));
    case ($urandom_range(5))
      0:       data = 16'd0;
      1:       data = 16'hFFFF;
      2:       data = 16'd1;
      3:       data = 16'd655;
      default: data = 16'($urandom_range(20000, 1000));
    endcase
    write_reg(CFG_BREATH_STEP, data);
  endtask

  task automatic start_phase(input int src, input int snk, input bit long_hold);
    @(posedge clk_i);
    src_idle_pct  = src;
    snk_stall_pct = snk;
    if (long_hold) hold_ticket++;
  endtask

  task automatic queue_tick(input logic blink, input logic ms);
    @(posedge clk_i);
    ticks_pending.push_back('{blink: blink, ms: ms});
    ticks_queued++;
  endtask

  task automatic queue_ticks(input int n, input int blink_pct, input int ms_pct);
    tick_t t;
    @(posedge clk_i);
    repeat (n) begin
      t.blink = ($urandom_range(99) < blink_pct);
      t.ms    = ($urandom_range(99) < ms_pct);
      ticks_pending.push_back(t);
      ticks_queued++;
    end
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (ticks_taken != ticks_queued || results_due.size() != 0);
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    in_if.valid      = 1'b0;
    in_if.blink_tick = 1'b0;
    in_if.ms_tick    = 1'b0;
    out_if.ready     = 1'b0;
    sel_work         = WORK_DARK;
    breath_on        = 1'b0;
    led_mask         = '0;
    ramp_interval    = 16'd1;
    ramp_inc         = 16'd655;
    for (int i = 0; i < NumLeds; i++) begin
      blink_period[i] = 16'd25;
      blink_cnt[i]    = '0;
    end
    pin_lvl   = '1;
    ramp_duty = '0;
    ramp_up   = 1'b1;
    ramp_cnt  = '0;
    flow_cnt  = '0;
    flow_pos  = '0;
    duty_q    = DutyFull;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, dark
    queue_tick(1'b0, 1'b0);
    queue_tick(1'b1, 1'b1);
    queue_tick(1'b1, 1'b0);
    queue_tick(1'b0, 1'b1);
    drain();
    // light, with and without the breathing led masked
    write_reg(CFG_WORK_SELECT, WORK_LIGHT);
    write_reg(CFG_COLOUR_MASK, 16'h000F);
    queue_tick(1'b0, 1'b0);
    queue_tick(1'b1, 1'b1);
    drain();
    write_reg(CFG_COLOUR_MASK, 16'h0006);
    queue_tick(1'b1, 1'b0);
    drain();
    // blink with zero period, interval zero, full step: ramp saturates both ways
    write_reg(CFG_WORK_SELECT, WORK_BLINK);
    write_reg(CFG_COLOUR_MASK, 16'h000B);
    write_reg(CFG_BLUE_PERIOD, 16'd0);
    write_reg(CFG_GREEN_PERIOD, 16'd1);
    write_reg(CFG_RED_PERIOD, 16'hFFFF);
    write_reg(CFG_BREATH_INTERVAL, 16'd0);
    write_reg(CFG_BREATH_STEP, 16'hFFFF);
    write_reg(CFG_BREATH_ENABLE, 16'd1);
    repeat (4) queue_tick(1'b1, 1'b0);
    queue_tick(1'b0, 1'b1);
    queue_tick(1'b1, 1'b1);
    drain();
    // blink without breathing keeps the duty
    write_reg(CFG_BREATH_ENABLE, 16'd0);
    queue_tick(1'b1, 1'b0);
    queue_tick(1'b1, 1'b0);
    drain();
    write_reg(CFG_WORK_SELECT, WORK_FLOW);
    queue_tick(1'b0, 1'b1);
    queue_tick(1'b1, 1'b1);
    drain();
    write_reg(CFG_WORK_SELECT, WORK_DARK);
    queue_tick(1'b1, 1'b1);
    drain();

    random_config(WORK_BLINK);
    start_phase(0, 0, 1'b1);
    queue_ticks(60, 70, 50);
    drain();

    random_config(WORK_LIGHT);
    start_phase(82, 0, 1'b0);
    queue_ticks(60, 60, 50);
    drain();

    random_config(work_e'($urandom_range(3)));
    start_phase(0, 82, 1'b0);
    queue_ticks(60, 60, 50);
    drain();

    // sender pauses midway until every result is back
    random_config(WORK_BLINK);
    start_phase(29, 29, 1'b0);
    queue_ticks(30, 80, 50);
    drain();
    queue_ticks(30, 80, 50);
    drain();

    // long flow run so the lit pin advances
    random_config(WORK_FLOW);
    start_phase(29, 29, 1'b0);
    queue_ticks(350, 50, 97);
    drain();

    random_config(WORK_DARK);
    start_phase(0, 0, 1'b0);
    queue_ticks(60, 60, 50);
    drain();

    random_config(WORK_BLINK);
    start_phase(82, 82, 1'b0);
    queue_ticks(60, 80, 50);
    drain();

    random_config(WORK_FLOW);
    start_phase(0, 0, 1'b0);
    queue_ticks(100, 50, 97);
    drain();

    repeat (4) @(negedge clk_i);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
